>>> rtl/core/sspr_pkg.sv
// Shared types, widths, codes and helpers for the soft starter phase ramp unit.
`timescale 1ns / 1ps

package sspr_pkg;

  // Defaults for the top level parameters
  localparam int unsigned HALF_CYCLE_COUNTS_DEF = 1500;
  localparam int unsigned PULSE_WIDTH_DEF       = 80;
  localparam int unsigned BYPASS_ANGLE_DEF      = 200;

  // Field widths
  localparam int PHASE_W   = 11;
  localparam int ADC_W     = 12;
  localparam int CUR_W     = 11;
  localparam int SECS_W    = 6;
  localparam int WIN_W     = 12;
  localparam int TICK_W    = 9;
  localparam int MODE_W    = 2;

  // Port widths
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;

  // Register reset values
  localparam logic [SECS_W-1:0] SECS_RST          = SECS_W'(10);
  localparam logic [CUR_W-1:0]  START_LIMIT_RST   = CUR_W'(700);
  localparam logic [CUR_W-1:0]  TRIP_CURRENT_RST  = CUR_W'(1000);
  localparam logic [CUR_W-1:0]  RELEASE_CURR_RST  = CUR_W'(80);
  localparam int unsigned       SECS_RST_VAL      = 10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_SECONDS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DECEL_SECONDS  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_START_LIMIT    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TRIP_CURRENT   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_CURR   = CFG_IDX_W'(4);

  // Ramp modes
  localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACCEL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DECEL  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } sspr_op_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;    // register the incoming word
    logic execute;    // apply the held item to the state
    logic cfg_write;  // write a configuration register
    logic div_start;  // start a step size division
    logic step_load;  // store the finished step size
  } sspr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic cfg_ramp_time;  // the write addresses a ramp time register
    logic div_done;       // divider has finished
  } sspr_stat_t;

  // Clamp a one-bit-wider window sum into the 12-bit signed range
  function automatic logic signed [WIN_W-1:0] sat_win(input logic signed [WIN_W:0] v);
    logic signed [WIN_W:0] hi;
    logic signed [WIN_W:0] lo;
    hi = (WIN_W+1)'((1 << (WIN_W-1)) - 1);
    lo = -hi - (WIN_W+1)'(1);
    if (v > hi) begin
      return hi[WIN_W-1:0];
    end else if (v < lo) begin
      return lo[WIN_W-1:0];
    end
    return v[WIN_W-1:0];
  endfunction

  // Sign extend a window value by one bit
  function automatic logic signed [WIN_W:0] ext_win(input logic signed [WIN_W-1:0] v);
    return {v[WIN_W-1], v};
  endfunction

endpackage

>>> rtl/core/sspr_div.sv
// Restoring divider: constant dividend over a small ramp time, one quotient bit a cycle.
`timescale 1ns / 1ps

module sspr_div #(
  parameter int unsigned DIVIDEND = 1500,
  parameter int unsigned QW       = 11
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [sspr_pkg::SECS_W-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [QW-1:0]              quotient
);
  import sspr_pkg::*;

  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0]     acc;
  logic [SECS_W-1:0] rem;
  logic [SECS_W-1:0] dsr;
  logic [CW-1:0]     cnt;
  logic [SECS_W:0]   rem_sh;
  logic [SECS_W:0]   rem_diff;
  logic              fits;

  assign rem_sh   = {rem, acc[QW-1]};
  assign fits     = rem_sh >= {1'b0, dsr};
  assign rem_diff = rem_sh - {1'b0, dsr};
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out at the top while quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= QW'(DIVIDEND);
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      acc <= {acc[QW-2:0], fits};
      rem <= fits ? rem_diff[SECS_W-1:0] : rem_sh[SECS_W-1:0];
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a running division");

endmodule

>>> rtl/core/sspr_dp.sv
// Datapath: configuration registers, item register, ramp state, latches and step sizes.
`timescale 1ns / 1ps

module sspr_dp #(
  parameter int unsigned HALF_CYCLE_COUNTS = sspr_pkg::HALF_CYCLE_COUNTS_DEF,
  parameter int unsigned PULSE_WIDTH       = sspr_pkg::PULSE_WIDTH_DEF,
  parameter int unsigned BYPASS_ANGLE      = sspr_pkg::BYPASS_ANGLE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  sspr_pkg::sspr_cmd_t             cmd,
  output sspr_pkg::sspr_stat_t            stat,
  input  logic [sspr_pkg::IN_TDATA_W-1:0] in_data,
  input  logic [sspr_pkg::IN_TUSER_W-1:0] in_user,
  input  logic [sspr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sspr_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [sspr_pkg::OUT_TDATA_W-1:0] out_data
);
  import sspr_pkg::*;

  localparam int QW = $clog2(HALF_CYCLE_COUNTS + 1);
  localparam int SW = QW - 3;
  localparam int WW = WIN_W + 1;
  localparam logic [SW-1:0] STEP_RST = SW'((HALF_CYCLE_COUNTS / SECS_RST_VAL) / 8);
  localparam logic signed [WIN_W-1:0] HALF_WIN = WIN_W'(HALF_CYCLE_COUNTS);
  localparam logic signed [WW-1:0] HALF_S   = WW'(HALF_CYCLE_COUNTS);
  localparam logic signed [WW-1:0] PW_S     = WW'(PULSE_WIDTH);
  localparam logic signed [WW-1:0] BYPASS_S = WW'(BYPASS_ANGLE);

  // Configuration
  logic [SECS_W-1:0] accel_secs, decel_secs;
  logic [CUR_W-1:0]  start_limit, trip_cur, release_cur;
  logic [SW-1:0]     accel_step, decel_step;
  logic              div_sel;

  // Held item
  sspr_op_t          item_op;
  logic [PHASE_W-1:0] item_phase;
  logic [ADC_W-1:0]  item_adc;
  logic              item_start, item_stop, item_mains, item_emerg;

  // Ramp state and latches
  logic [MODE_W-1:0]        mode, mode_next;
  logic                     ramp_running, ramp_running_next;
  logic signed [WIN_W-1:0]  accel_win_end, accel_win_end_next;
  logic signed [WIN_W-1:0]  decel_win_start, decel_win_start_next;
  logic signed [WIN_W-1:0]  win_start, win_start_next;
  logic signed [WIN_W-1:0]  win_end, win_end_next;
  logic [TICK_W-1:0]        eighth_ticks, eighth_ticks_next;
  logic [CUR_W-1:0]         last_current, last_current_next;
  logic                     fire, fire_next;
  logic                     bypass, bypass_next;
  logic                     over, over_next;
  logic                     mains, mains_next;

  // Divider
  logic [SECS_W-1:0] div_in;
  logic              div_busy, div_done;
  logic [QW-1:0]     div_q;

  assign div_in = (cfg_data[SECS_W-1:0] == '0) ? SECS_W'(1) : cfg_data[SECS_W-1:0];

  sspr_div #(
    .DIVIDEND (HALF_CYCLE_COUNTS),
    .QW       (QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .divisor  (div_in),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign stat.cfg_ramp_time = (cfg_index == REG_ACCEL_SECONDS) ||
                              (cfg_index == REG_DECEL_SECONDS);
  assign stat.div_done      = div_done && !div_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_secs  <= SECS_RST;
      decel_secs  <= SECS_RST;
      start_limit <= START_LIMIT_RST;
      trip_cur    <= TRIP_CURRENT_RST;
      release_cur <= RELEASE_CURR_RST;
      accel_step  <= STEP_RST;
      decel_step  <= STEP_RST;
      div_sel     <= 1'b0;
    end else begin
      if (cmd.cfg_write) begin
        div_sel <= (cfg_index == REG_DECEL_SECONDS);
        case (cfg_index)
          REG_ACCEL_SECONDS: accel_secs  <= cfg_data[SECS_W-1:0];
          REG_DECEL_SECONDS: decel_secs  <= cfg_data[SECS_W-1:0];
          REG_START_LIMIT:   start_limit <= cfg_data[CUR_W-1:0];
          REG_TRIP_CURRENT:  trip_cur    <= cfg_data[CUR_W-1:0];
          REG_RELEASE_CURR:  release_cur <= cfg_data[CUR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.step_load) begin
        if (div_sel) begin
          decel_step <= div_q[QW-1:3];
        end else begin
          accel_step <= div_q[QW-1:3];
        end
      end
    end
  end

  // tdata: phase[10:0], adc[22:11], start, stop, mains toggle, emergency
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_op    <= sspr_op_t'(in_user[0]);
      item_phase <= in_data[PHASE_W-1:0];
      item_adc   <= in_data[PHASE_W +: ADC_W];
      item_start <= in_data[PHASE_W+ADC_W];
      item_stop  <= in_data[PHASE_W+ADC_W+1];
      item_mains <= in_data[PHASE_W+ADC_W+2];
      item_emerg <= in_data[PHASE_W+ADC_W+3];
    end
  end

  always_comb begin
    logic [CUR_W-1:0]        cur;
    logic                    old_over;
    logic                    old_bypass;
    logic                    do_reset;
    logic signed [WIN_W-1:0] sa;
    logic signed [WIN_W-1:0] sd;
    logic signed [WW-1:0]    phase_s;

    mode_next            = mode;
    ramp_running_next    = ramp_running;
    accel_win_end_next   = accel_win_end;
    decel_win_start_next = decel_win_start;
    win_start_next       = win_start;
    win_end_next         = win_end;
    eighth_ticks_next    = eighth_ticks;
    last_current_next    = last_current;
    fire_next            = fire;
    bypass_next          = bypass;
    over_next            = over;
    mains_next           = mains;

    cur        = item_adc[ADC_W-1:1];
    old_over   = over;
    old_bypass = bypass;
    do_reset   = 1'b0;
    sa         = '0;
    sd         = WIN_W'(decel_step);
    phase_s    = $signed({{(WW-PHASE_W){1'b0}}, item_phase});

    if (cmd.execute) begin
      if (item_op == OP_TICK) begin
        if (ramp_running) begin
          if (last_current < start_limit) begin
            sa                = WIN_W'(accel_step);
            eighth_ticks_next = eighth_ticks + TICK_W'(1);
          end
          if (mode == MODE_ACCEL && accel_win_end != sa) begin
            accel_win_end_next = sat_win(ext_win(accel_win_end) - ext_win(sa));
            win_start_next     = sat_win(ext_win(accel_win_end_next) - PW_S);
            win_end_next       = accel_win_end_next;
            if (ext_win(win_start_next) <= BYPASS_S) begin
              bypass_next = 1'b1;
            end
            if (eighth_ticks_next == {accel_secs, 3'b000}) begin
              ramp_running_next    = 1'b0;
              eighth_ticks_next    = '0;
              decel_win_start_next = '0;
            end
          end
          if (mode == MODE_DECEL && ext_win(decel_win_start) <= HALF_S) begin
            decel_win_start_next = sat_win(ext_win(decel_win_start) + ext_win(sd));
            win_start_next       = decel_win_start_next;
            win_end_next         = sat_win(ext_win(decel_win_start_next) + PW_S);
            if (eighth_ticks_next == {decel_secs, 3'b000}) begin
              ramp_running_next  = 1'b0;
              eighth_ticks_next  = '0;
              accel_win_end_next = HALF_WIN;
            end
          end
        end
      end else begin
        last_current_next = cur;
        if (cur >= trip_cur) begin
          over_next   = 1'b1;
          bypass_next = 1'b0;
        end
        // release is judged on the latch as it stood before this sample
        if (cur < release_cur && old_over) begin
          over_next = 1'b0;
          do_reset  = 1'b1;
        end
        if (do_reset) begin
          mode_next            = MODE_IDLE;
          ramp_running_next    = 1'b0;
          accel_win_end_next   = HALF_WIN;
          decel_win_start_next = '0;
          win_start_next       = '0;
          win_end_next         = '0;
          eighth_ticks_next    = '0;
        end
        if (!win_start_next[WIN_W-1] && win_start_next != '0) begin
          fire_next = (phase_s >= ext_win(win_start_next)) &&
                      (phase_s <= ext_win(win_end_next));
        end
        if (item_start && !old_bypass) begin
          mode_next         = MODE_ACCEL;
          ramp_running_next = 1'b1;
        end
        if (item_stop && old_bypass) begin
          mode_next         = MODE_DECEL;
          ramp_running_next = 1'b1;
          bypass_next       = 1'b0;
        end
        if (item_mains) begin
          mains_next = !mains;
        end
        if (item_emerg) begin
          mains_next = 1'b0;
        end
        if (item_mains || item_emerg) begin
          mode_next            = MODE_IDLE;
          ramp_running_next    = 1'b0;
          accel_win_end_next   = HALF_WIN;
          decel_win_start_next = '0;
          win_start_next       = '0;
          win_end_next         = '0;
          eighth_ticks_next    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_IDLE;
      ramp_running    <= 1'b0;
      accel_win_end   <= HALF_WIN;
      decel_win_start <= '0;
      win_start       <= '0;
      win_end         <= '0;
      eighth_ticks    <= '0;
      last_current    <= '0;
      fire            <= 1'b0;
      bypass          <= 1'b0;
      over            <= 1'b0;
      mains           <= 1'b0;
    end else begin
      mode            <= mode_next;
      ramp_running    <= ramp_running_next;
      accel_win_end   <= accel_win_end_next;
      decel_win_start <= decel_win_start_next;
      win_start       <= win_start_next;
      win_end         <= win_end_next;
      eighth_ticks    <= eighth_ticks_next;
      last_current    <= last_current_next;
      fire            <= fire_next;
      bypass          <= bypass_next;
      over            <= over_next;
      mains           <= mains_next;
    end
  end

  // latches only move on execute, so they double as the output register
  assign out_data = {1'b0, ramp_running, mode, mains, over, bypass, fire};

  a_running_has_mode: assert property (@(posedge clk) disable iff (rst)
    ramp_running |-> mode != MODE_IDLE)
    else $error("ramp running with no mode");

  a_mode_valid: assert property (@(posedge clk) disable iff (rst)
    mode != MODE_UNUSED)
    else $error("unused ramp mode reached");

endmodule

>>> rtl/core/sspr_ctrl.sv
// Controller: sequences capture, execute, configuration writes and step size refresh.
`timescale 1ns / 1ps

module sspr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  sspr_pkg::sspr_stat_t stat,
  output sspr_pkg::sspr_cmd_t  cmd
);
  import sspr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DIV  = 3'b100
  } sspr_state_t;

  sspr_state_t state, state_next;
  logic        out_valid;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    cfg_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        cfg_ready = !s_tvalid;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end else if (cfg_valid) begin
          cmd.cfg_write = 1'b1;
          if (stat.cfg_ramp_time) begin
            cmd.div_start = 1'b1;
            state_next    = ST_DIV;
          end
        end
      end
      ST_EXEC: begin
        if (!out_valid || m_tready) begin
          cmd.execute = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.step_load = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.execute) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;

  a_pending_word_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |=> out_valid)
    else $error("result word dropped before it was taken");

  a_no_accept_in_div: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !s_tready && !cfg_ready)
    else $error("input or write accepted while the step size is refreshed");

  a_capture_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == ST_EXEC)
    else $error("captured word not executed");

endmodule

>>> rtl/core/soft_starter_phase_ramp_unit.sv
// Top level of the soft starter phase ramp unit: controller plus datapath.
`timescale 1ns / 1ps

// Channel   Dir  Signals                                   Word
// s_axis    in   s_axis_tvalid/tready, tdata[31:0], tuser  one sample or ramp tick
// m_axis    out  m_axis_tvalid/tready, tdata[7:0]          latch and ramp state after it
// cfg       in   cfg_valid/ready, cfg_index[2:0], data     one register write
//
// An input word is taken into the item register and applied once the output word is free
// or is being taken; the result shows the cycle after. No new input word is taken until then.
// The output word may wait while the next input word is already being taken.
// Writing a ramp time refreshes its step size on the shared divider, one quotient bit a
// cycle; no word is taken while the division runs. Reset is synchronous (rst high) and
// clears all state but the held item and the divider operands; no clearing pass follows.

module soft_starter_phase_ramp_unit #(
  parameter int unsigned HALF_CYCLE_COUNTS = sspr_pkg::HALF_CYCLE_COUNTS_DEF,
  parameter int unsigned PULSE_WIDTH       = sspr_pkg::PULSE_WIDTH_DEF,
  parameter int unsigned BYPASS_ANGLE      = sspr_pkg::BYPASS_ANGLE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // phase_count[10:0], adc_sample[22:11], start_button[23], stop_button[24],
  // mains_toggle_button[25], emergency_button[26], zero [31:27]
  input  logic [sspr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // operation[0]: 0 sample, 1 ramp tick
  input  logic [sspr_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // fire[0], bypass_relay[1], overcurrent[2], mains_relay[3], ramp_mode[5:4],
  // ramp_active[6], zero [7]
  output logic [sspr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sspr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sspr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sspr_pkg::*;

  sspr_cmd_t  cmd;
  sspr_stat_t stat;

  sspr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_axis_tvalid),
    .s_tready  (s_axis_tready),
    .m_tvalid  (m_axis_tvalid),
    .m_tready  (m_axis_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sspr_dp #(
    .HALF_CYCLE_COUNTS (HALF_CYCLE_COUNTS),
    .PULSE_WIDTH       (PULSE_WIDTH),
    .BYPASS_ANGLE      (BYPASS_ANGLE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (m_axis_tdata)
  );

endmodule
